// File: src/binary_min_heap_priority_queue_top_macros.svh
// assertion macros for the binary min-heap priority queue
// used by binary_min_heap_priority_queue_top; expects clk and rst in scope
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BMHPQ_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("bmhpq check failed");
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmhpq sequence check failed");
`else
`define BMHPQ_ASSERT(lbl, expr)
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/bmhpq_pkg.sv
// shared constants, codes and key helpers for the heap priority queue
// no dependencies
`timescale 1ns / 1ps

package bmhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_MAX  = CAPACITY - 1;
  localparam int CFG_W    = 10;
  localparam int CMP_W    = (ADDR_W > CFG_W) ? ADDR_W : CFG_W;

  localparam logic [CFG_W-1:0] CAP_RESET = 10'd1023;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  // signed compare of two stored keys
  function automatic logic key_less(input key_t a, input key_t b);
    return $signed(a) < $signed(b);
  endfunction

  // sign-extend or cut a stored key to the 32-bit result field
  function automatic logic signed [31:0] key_to_out(input key_t k);
    logic signed [KEY_BITS-1:0] ks;
    ks = $signed(k);
    return 32'(ks);
  endfunction

endpackage

// File: src/bmhpq_ram.sv
// generic ram: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps

module bmhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// File: src/binary_min_heap_priority_queue_top.sv
// the result strobe (done) rises in the cycle after start is accepted
// peek, flagged items and a lone-key extract leave busy low; next item next cycle;
// insert keeps busy high while it climbs: at each level a ram read of the parent, then a
// compare/write, until it writes at the root or stops lower; extract fetches the last key,
// then per level reads both children and compares/writes until a leaf or it stops higher
// reset: rst (synchronous) empties the queue and restores capacity_in_use to 1023; heap memory
// is not cleared, and entries past the count are never used; done cannot stall
`timescale 1ns / 1ps

`include "binary_min_heap_priority_queue_top_macros.svh"

module binary_min_heap_priority_queue_top
  import bmhpq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] key,
  // result channel
  output logic               done,
  output logic signed [31:0] min_key,
  output logic [9:0]         count,
  output logic [1:0]         status,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EX_LAST = 3'd1;  // last key arriving from the ram
  localparam logic [2:0] S_UP_RD   = 3'd2;  // issue parent read
  localparam logic [2:0] S_UP_CMP  = 3'd3;  // compare moving key with parent
  localparam logic [2:0] S_DN_RD   = 3'd4;  // issue both child reads
  localparam logic [2:0] S_DN_CMP  = 3'd5;  // pick smaller child, compare

  logic [2:0]       state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;     // keys held
  addr_t            pos, pos_next;      // hole being moved up or down
  key_t             mkey, mkey_next;    // key looking for its slot
  key_t             root;               // copy of slot 1 for the result
  logic [CFG_W-1:0] capacity_in_use;

  // ram ports
  logic  ram_we;
  addr_t ram_waddr, ra_addr, rb_addr;
  key_t  ram_wdata, ra_data, rb_data;

  logic  accept;
  logic  full;
  logic  insert_taken;
  logic [1:0] status_next;
  logic [CMP_W-1:0] limit;

  // child indexes need one extra bit
  logic [ADDR_W:0] child_l, child_r, cnt_wide;
  logic            has_right, pick_r;
  key_t            pick_key;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  // ---------------------------------------------------------------------
  // configuration register: one word, address bit 2 selects the index
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_in_use) : 32'd0;

  // effective limit is the smaller of the register and CNT_MAX, the usable slots
  always_comb begin
    if (CMP_W'(capacity_in_use) < CMP_W'(CNT_MAX)) begin
      limit = CMP_W'(capacity_in_use);
    end else begin
      limit = CMP_W'(CNT_MAX);
    end
  end

  assign full = (CMP_W'(cnt) >= limit);
  assign insert_taken = accept && (opcode == OP_INSERT) && !full;

  // ---------------------------------------------------------------------
  // heap storage, 1-based, slot 0 unused
  // ---------------------------------------------------------------------
  bmhpq_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  assign child_l   = {pos, 1'b0};
  assign child_r   = {pos, 1'b1};
  assign cnt_wide  = {1'b0, cnt};
  assign has_right = (child_r <= cnt_wide);
  assign pick_r    = has_right && key_less(rb_data, ra_data);
  assign pick_key  = pick_r ? rb_data : ra_data;

  // ---------------------------------------------------------------------
  // sift sequencer: the moving key stays in mkey and is written once at
  // the end while the hole walks through the tree, so no read ever overlaps a
  // pending write to the same entry
  // ---------------------------------------------------------------------
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    pos_next    = pos;
    mkey_next   = mkey;
    ram_we      = 1'b0;
    ram_waddr   = pos;
    ram_wdata   = mkey;
    ra_addr     = cnt;
    rb_addr     = cnt;
    status_next = ST_DONE;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (opcode == OP_INSERT) begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              cnt_next   = cnt + ADDR_W'(1);
              pos_next   = cnt + ADDR_W'(1);
              mkey_next  = KEY_BITS'($unsigned(key));
              state_next = S_UP_RD;
            end
          end else if (opcode == OP_EXTRACT) begin
            if (cnt == '0) begin
              status_next = ST_EMPTY;
            end else begin
              cnt_next = cnt - ADDR_W'(1);
              pos_next = ADDR_W'(1);
              ra_addr  = cnt;  // fetch the last key
              // a lone key leaves nothing to reorder
              if (cnt != ADDR_W'(1)) begin
                state_next = S_EX_LAST;
              end
            end
          end else begin
            // peek, and the unused code acts as peek
            if (cnt == '0) begin
              status_next = ST_EMPTY;
            end
          end
        end
      end

      S_EX_LAST: begin
        mkey_next  = ra_data;
        state_next = S_DN_RD;
      end

      S_UP_RD: begin
        if (pos == ADDR_W'(1)) begin
          ram_we     = 1'b1;
          state_next = S_IDLE;
        end else begin
          ra_addr    = pos >> 1;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (key_less(mkey, ra_data)) begin
          // parent moves down into the hole
          ram_wdata  = ra_data;
          pos_next   = pos >> 1;
          state_next = S_UP_RD;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_DN_RD: begin
        if (child_l > cnt_wide) begin
          ram_we     = 1'b1;
          state_next = S_IDLE;
        end else begin
          ra_addr    = ADDR_W'(child_l);
          rb_addr    = ADDR_W'(child_r);  // ignored past the end
          state_next = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (key_less(pick_key, mkey)) begin
          // smaller child moves up into the hole
          ram_wdata  = pick_key;
          pos_next   = pick_r ? ADDR_W'(child_r) : ADDR_W'(child_l);
          state_next = S_DN_RD;
        end else begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= accept;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos  <= pos_next;
    mkey <= mkey_next;
    if (ram_we && (ram_waddr == ADDR_W'(1))) begin
      root <= ram_wdata;
    end
    if (accept) begin
      min_key <= (cnt != '0) ? key_to_out(root) : 32'sd0;
      count   <= 10'(cnt_next);
      status  <= status_next;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `BMHPQ_ASSERT_NEXT(a_done_after_accept, accept, done)
  `BMHPQ_ASSERT_NEXT(a_no_spurious_done, !accept, !done)
  `BMHPQ_ASSERT(a_count_in_range, CMP_W'(cnt) <= CMP_W'(CNT_MAX))
  `BMHPQ_ASSERT(a_busy_needs_keys, !busy || (cnt != '0))
  `BMHPQ_ASSERT_NEXT(a_insert_grows, insert_taken, cnt == $past(cnt) + ADDR_W'(1))

endmodule
